>>> design/pnp_pkg.sv
// ----------------------------------------------------------------------------
// pnp_pkg
// shared types and constants of the point-in-polygon block
// ----------------------------------------------------------------------------
package pnp_pkg;

  localparam int unsigned FieldW = 32;

  typedef struct packed {
    logic first;
    logic cross_a;
    logic neg_a;
    logic cross_b;
    logic neg_b;
    logic close;
    logic hole;
    logic plast;
  } pnp_flags_t;

  localparam int unsigned FlagW = $bits(pnp_flags_t);

  typedef struct packed {
    logic in_poly;
    logic outer;
    logic hole;
  } pnp_res_t;

endpackage

>>> design/pnp_if.sv
// ----------------------------------------------------------------------------
// pnp_if
// vertex and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface pnp_in_if import pnp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [FieldW-1:0] point_x;
  logic [FieldW-1:0] point_y;
  logic [FieldW-1:0] vert_x;
  logic [FieldW-1:0] vert_y;
  logic              ring_first;
  logic              ring_last;
  logic              is_hole;
  logic              polygon_last;

  modport source (
    output valid, point_x, point_y, vert_x, vert_y,
    output ring_first, ring_last, is_hole, polygon_last,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, vert_x, vert_y,
    input  ring_first, ring_last, is_hole, polygon_last,
    output ready
  );
endinterface

interface pnp_out_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic outer_hit;
  logic hole_hit;

  modport source (output valid, inside_res, outer_hit, hole_hit, input ready);
  modport sink (input valid, inside_res, outer_hit, hole_hit, output ready);
endinterface

>>> design/pnp_front.sv
// ----------------------------------------------------------------------------
// pnp_front
// takes vertex transfers, tracks ring start and previous vertex, forms the
// operands of both edge tests
// ----------------------------------------------------------------------------
module pnp_front import pnp_pkg::*; #(
  parameter int unsigned CoordW = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  pnp_in_if.sink                            in_i,
  input  logic                              full_i,
  output logic                              push_o,
  output logic [FlagW+8*(CoordW+1)-1:0]     ent_o
);

  localparam int unsigned DiffW = CoordW + 1;

  typedef struct packed {
    pnp_flags_t              flags;
    logic signed [DiffW-1:0] a_px;
    logic signed [DiffW-1:0] a_d;
    logic signed [DiffW-1:0] a_bx;
    logic signed [DiffW-1:0] a_dy;
    logic signed [DiffW-1:0] b_px;
    logic signed [DiffW-1:0] b_d;
    logic signed [DiffW-1:0] b_bx;
    logic signed [DiffW-1:0] b_dy;
  } pnp_ent_t;

  function automatic logic signed [CoordW-1:0] to_coord(input logic [FieldW-1:0] f);
    return CoordW'(f);
  endfunction

  function automatic logic signed [DiffW-1:0] diff(input logic signed [CoordW-1:0] a,
                                                   input logic signed [CoordW-1:0] b);
    return DiffW'(a) - DiffW'(b);
  endfunction

  logic signed [CoordW-1:0] prev_x_q, prev_y_q, start_x_q, start_y_q;
  logic signed [CoordW-1:0] prev_x_d, prev_y_d, start_x_d, start_y_d;
  logic signed [CoordW-1:0] px, py, vx, vy, sx, sy;
  logic                     accept;
  logic                     close;
  pnp_ent_t                 ent;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;
  assign push_o     = accept;

  always_comb begin
    px    = to_coord(in_i.point_x);
    py    = to_coord(in_i.point_y);
    vx    = to_coord(in_i.vert_x);
    vy    = to_coord(in_i.vert_y);
    sx    = in_i.ring_first ? vx : start_x_q;
    sy    = in_i.ring_first ? vy : start_y_q;
    close = in_i.ring_last || in_i.polygon_last;

    // edge from current vertex to previous one
    ent.a_px = diff(px, vx);
    ent.a_d  = diff(prev_y_q, vy);
    ent.a_bx = diff(prev_x_q, vx);
    ent.a_dy = diff(py, vy);
    // closing edge from ring start to current vertex
    ent.b_px = diff(px, sx);
    ent.b_d  = diff(vy, sy);
    ent.b_bx = diff(vx, sx);
    ent.b_dy = diff(py, sy);

    ent.flags.first   = in_i.ring_first;
    ent.flags.cross_a = !in_i.ring_first && ((vy > py) != (prev_y_q > py));
    ent.flags.neg_a   = ent.a_d[DiffW-1];
    ent.flags.cross_b = close && ((sy > py) != (vy > py));
    ent.flags.neg_b   = ent.b_d[DiffW-1];
    ent.flags.close   = close;
    ent.flags.hole    = in_i.is_hole;
    ent.flags.plast   = in_i.polygon_last;

    prev_x_d  = accept ? vx : prev_x_q;
    prev_y_d  = accept ? vy : prev_y_q;
    start_x_d = (accept && in_i.ring_first) ? vx : start_x_q;
    start_y_d = (accept && in_i.ring_first) ? vy : start_y_q;
  end

  assign ent_o = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      start_x_q <= '0;
      start_y_q <= '0;
    end else begin
      prev_x_q  <= prev_x_d;
      prev_y_q  <= prev_y_d;
      start_x_q <= start_x_d;
      start_y_q <= start_y_d;
    end
  end

endmodule

>>> design/pnp_queue.sv
// ----------------------------------------------------------------------------
// pnp_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
module pnp_queue #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] data_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count above depth");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && full_o |-> pop_i)
    else $error("push into full queue");

endmodule

>>> design/pnp_back.sv
// ----------------------------------------------------------------------------
// pnp_back
// multiplies the edge operands, compares, tracks ring parity and marks,
// holds the result in an output register
// ----------------------------------------------------------------------------
module pnp_back import pnp_pkg::*; #(
  parameter int unsigned CoordW = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  logic [FlagW+8*(CoordW+1)-1:0] ent_i,
  output logic                          pop_o,
  pnp_out_if.source                     out_o
);

  localparam int unsigned DiffW = CoordW + 1;
  localparam int unsigned ProdW = 2 * DiffW;

  typedef struct packed {
    pnp_flags_t              flags;
    logic signed [DiffW-1:0] a_px;
    logic signed [DiffW-1:0] a_d;
    logic signed [DiffW-1:0] a_bx;
    logic signed [DiffW-1:0] a_dy;
    logic signed [DiffW-1:0] b_px;
    logic signed [DiffW-1:0] b_d;
    logic signed [DiffW-1:0] b_bx;
    logic signed [DiffW-1:0] b_dy;
  } pnp_ent_t;

  pnp_ent_t                ent;
  pnp_flags_t              s1_flags_q;
  logic                    s1_valid_q, s1_valid_d;
  logic signed [ProdW-1:0] la_q, ra_q, lb_q, rb_q;
  logic                    par_q, par_d, outer_q, outer_d, hole_q, hole_d;
  logic                    out_valid_q, out_valid_d;
  pnp_res_t                res_q, res_d;
  logic                    commit, advance, hit_a, hit_b, par;

  assign ent = ent_i;

  assign commit  = s1_valid_q && (!s1_flags_q.plast || !out_valid_q || out_o.ready);
  assign advance = !s1_valid_q || commit;
  assign pop_o   = advance && !empty_i;

  // a negative edge height (a_d, b_d) flips the sense of the cross-multiplied compare
  assign hit_a = s1_flags_q.neg_a ? (ra_q < la_q) : (la_q < ra_q);
  assign hit_b = s1_flags_q.neg_b ? (rb_q < lb_q) : (lb_q < rb_q);

  always_comb begin
    s1_valid_d  = advance ? !empty_i : s1_valid_q;
    par_d       = par_q;
    outer_d     = outer_q;
    hole_d      = hole_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_o.ready;
    par         = par_q;
    if (commit) begin
      if (s1_flags_q.first) begin
        par = 1'b0;
      end else if (s1_flags_q.cross_a && hit_a) begin
        par = !par;
      end
      if (s1_flags_q.close) begin
        if (s1_flags_q.cross_b && hit_b) begin
          par = !par;
        end
        if (s1_flags_q.hole) begin
          hole_d = hole_q || par;
        end else begin
          outer_d = outer_q || par;
        end
        par = 1'b0;
      end
      par_d = par;
      if (s1_flags_q.plast) begin
        res_d.in_poly = outer_d && !hole_d;
        res_d.outer   = outer_d;
        res_d.hole    = hole_d;
        out_valid_d   = 1'b1;
        par_d         = 1'b0;
        outer_d       = 1'b0;
        hole_d        = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_flags_q <= ent.flags;
      la_q       <= ent.a_px * ent.a_d;
      ra_q       <= ent.a_bx * ent.a_dy;
      lb_q       <= ent.b_px * ent.b_d;
      rb_q       <= ent.b_bx * ent.b_dy;
    end
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      par_q       <= 1'b0;
      outer_q     <= 1'b0;
      hole_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      par_q       <= par_d;
      outer_q     <= outer_d;
      hole_q      <= hole_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.inside_res = res_q.in_poly;
  assign out_o.outer_hit  = res_q.outer;
  assign out_o.hole_hit   = res_q.hole;

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && s1_flags_q.plast |=> out_valid_q)
    else $error("polygon end without result");

  a_marks_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && s1_flags_q.plast |=> !par_q && !outer_q && !hole_q)
    else $error("marks not cleared after result");

  a_no_result_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && s1_flags_q.plast |-> !out_valid_q || out_o.ready)
    else $error("result register overwritten");

endmodule

>>> design/point_in_polygon_with_holes_top.sv
// ----------------------------------------------------------------------------
// point_in_polygon_with_holes_top
// crossing-number point-in-polygon test for polygons with holes
// ----------------------------------------------------------------------------
// Vertices stream in one per transfer, ring after ring, each carrying the
// query point and ring/polygon marks; on the polygon's last vertex one result
// transfer gives inside, outer-ring hit and hole hit. The block takes one
// vertex every cycle unless the queue is full: the front keeps ring start and
// previous vertex and forms both edge tests' differences in the cycle of the
// transfer, a two-entry queue decouples it from the back, whose four
// multipliers are registered and whose compare and parity update act on those
// registers and load a result register that can be drained in the same cycle
// it is refilled.
module point_in_polygon_with_holes_top import pnp_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pnp_in_if.sink    in_i,
  pnp_out_if.source out_o
);

  localparam int unsigned EntW = FlagW + 8 * (COORD_WIDTH + 1);

  logic            push, pop, full, empty;
  logic [EntW-1:0] ent_in, ent_out;

  pnp_front #(.CoordW(COORD_WIDTH)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .ent_o  (ent_in)
  );

  pnp_queue #(.Width(EntW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (ent_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (ent_out)
  );

  pnp_back #(.CoordW(COORD_WIDTH)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .ent_i   (ent_out),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

>>> tb/sv/pnp_result_checker.sv
// ----------------------------------------------------------------------------
// pnp_result_checker
// Watches the vertex and result channels of the point-in-polygon block.
// Each accepted vertex is run through an exact crossing-number model with its
// own ring and polygon marks. Every polygon end queues one expected result.
// Each accepted result is compared field by field with the oldest entry.
// The checker hands the failure count and the number of outstanding results
// to the testbench top.
// ----------------------------------------------------------------------------
module pnp_result_checker import pnp_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  pnp_in_if    in_mon_i,
  pnp_out_if   out_mon_i,
  output int   mismatch_cnt_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [63:0] prev_vx, prev_vy, ring_x0, ring_y0;
  logic               ring_odd, outer_odd, hole_odd;
  pnp_res_t           expected_res_q[$];
  int                 fail_cnt;

  initial begin
    prev_vx = '0;
    prev_vy = '0;
    ring_x0 = '0;
    ring_y0 = '0;
    ring_odd = 1'b0;
    outer_odd = 1'b0;
    hole_odd = 1'b0;
    fail_cnt = 0;
  end

  // low COORD_WIDTH bits of a field as two's complement
  function automatic logic signed [63:0] to_coord(input logic [FieldW-1:0] f);
    logic signed [63:0] w;
    w = {{(64-FieldW){1'b0}}, f};
    w = w <<< (64 - COORD_WIDTH);
    return w >>> (64 - COORD_WIDTH);
  endfunction

  // exact test of edge (a, b) against the ray from the point toward +x
  function automatic logic ray_crosses(input logic signed [63:0] px, py, ax, ay, bx, by);
    logic signed [63:0]  d, dy;
    logic signed [127:0] lhs_a, lhs_b, rhs_a, rhs_b;
    if ((ay > py) == (by > py)) return 1'b0;
    d = by - ay;
    dy = py - ay;
    if (d < 0) begin
      d = -d;
      dy = -dy;
    end
    lhs_a = px - ax;
    lhs_b = d;
    rhs_a = bx - ax;
    rhs_b = dy;
    return (lhs_a * lhs_b) < (rhs_a * rhs_b);
  endfunction

  task automatic predict_vertex(input logic [FieldW-1:0] px_f, py_f, vx_f, vy_f,
                                input logic first, last, hole, plast);
    logic signed [63:0] px, py, vx, vy;
    logic               odd;
    pnp_res_t           res;
    px = to_coord(px_f);
    py = to_coord(py_f);
    vx = to_coord(vx_f);
    vy = to_coord(vy_f);
    odd = ring_odd;
    if (first) begin
      ring_x0 = vx;
      ring_y0 = vy;
      odd = 1'b0;
    end else if (ray_crosses(px, py, vx, vy, prev_vx, prev_vy)) begin
      odd = ~odd;
    end
    prev_vx = vx;
    prev_vy = vy;
    // closing edge, also when the polygon ends without a ring end
    if (last || plast) begin
      if (ray_crosses(px, py, ring_x0, ring_y0, vx, vy)) odd = ~odd;
      if (hole) hole_odd = hole_odd | odd;
      else outer_odd = outer_odd | odd;
      odd = 1'b0;
    end
    ring_odd = odd;
    if (plast) begin
      res.in_poly = outer_odd & ~hole_odd;
      res.outer = outer_odd;
      res.hole = hole_odd;
      expected_res_q = {expected_res_q, res};
      ring_odd = 1'b0;
      outer_odd = 1'b0;
      hole_odd = 1'b0;
    end
  endtask

  always @(posedge clk_i) begin : monitor
    pnp_res_t want, got;
    if (rst_ni) begin
      if (out_mon_i.valid && out_mon_i.ready) begin
        got.in_poly = out_mon_i.inside_res;
        got.outer = out_mon_i.outer_hit;
        got.hole = out_mon_i.hole_hit;
        if (expected_res_q.size() == 0) begin
          if (fail_cnt < 10) begin
            $display("%0t: unexpected result inside=%0b outer=%0b hole=%0b",
                     $realtime, got.in_poly, got.outer, got.hole);
          end
          fail_cnt++;
        end else begin
          want = expected_res_q.pop_front();
          if (want != got) begin
            if (fail_cnt < 10) begin
              $display("%0t: mismatch expected inside=%0b outer=%0b hole=%0b, got %0b %0b %0b",
                       $realtime, want.in_poly, want.outer, want.hole,
                       got.in_poly, got.outer, got.hole);
            end
            fail_cnt++;
          end
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        predict_vertex(in_mon_i.point_x, in_mon_i.point_y, in_mon_i.vert_x,
                       in_mon_i.vert_y, in_mon_i.ring_first, in_mon_i.ring_last,
                       in_mon_i.is_hole, in_mon_i.polygon_last);
      end
      mismatch_cnt_o <= fail_cnt;
      pending_o <= expected_res_q.size();
    end
  end

endmodule

>>> tb/sv/tb_point_in_polygon_with_holes_top.sv
// ----------------------------------------------------------------------------
// tb_point_in_polygon_with_holes_top
// Testbench top for the point-in-polygon block.
// A directed set of rings covers the extreme coordinates and the odd flag
// sequences. Random polygons with holes and some flag noise follow. Traffic
// is bursty on the vertex side and back-pressured on the result side,
// including one long result stall and one full drain. The checker beside the
// block does the prediction; this module drives stimulus and reports.
// ----------------------------------------------------------------------------
module tb_point_in_polygon_with_holes_top import pnp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CoordW      = 32;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned RandomItems = 450;

  typedef logic [FieldW-1:0] coord_t;

  logic clk;
  logic rst_n;
  logic long_hold_req;
  int   mismatch_cnt;
  int   pending_cnt;
  int   sent_cnt;
  int   burst_left;

  pnp_in_if  vtx_ch();
  pnp_out_if res_ch();

  point_in_polygon_with_holes_top #(
    .COORD_WIDTH(CoordW)
  ) u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (vtx_ch),
    .out_o (res_ch)
  );

  pnp_result_checker #(
    .COORD_WIDTH(CoordW)
  ) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_mon_i      (vtx_ch),
    .out_mon_i     (res_ch),
    .mismatch_cnt_o(mismatch_cnt),
    .pending_o     (pending_cnt)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("point_in_polygon_with_holes_top regression: fail");
    $finish;
  end

  function automatic coord_t jitter(input coord_t base, input int unsigned span);
    return base + $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic coord_t wild_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic offer_vertex(input coord_t px, py, vx, vy,
                              input logic first, last, hole, plast);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        vtx_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    vtx_ch.valid <= 1'b1;
    vtx_ch.point_x <= px;
    vtx_ch.point_y <= py;
    vtx_ch.vert_x <= vx;
    vtx_ch.vert_y <= vy;
    vtx_ch.ring_first <= first;
    vtx_ch.ring_last <= last;
    vtx_ch.is_hole <= hole;
    vtx_ch.polygon_last <= plast;
    @(posedge clk);
    while (!vtx_ch.ready) @(posedge clk);
    sent_cnt++;
  endtask

  task automatic tri_ring(input coord_t px, py, x0, y0, x1, y1, x2, y2,
                          input logic hole, close_poly);
    offer_vertex(px, py, x0, y0, 1'b1, 1'b0, hole, 1'b0);
    offer_vertex(px, py, x1, y1, 1'b0, 1'b0, hole, 1'b0);
    offer_vertex(px, py, x2, y2, 1'b0, 1'b1, hole, close_poly);
  endtask

  task automatic square_ring(input coord_t px, py, cx, cy, half,
                             input logic hole, close_poly);
    offer_vertex(px, py, cx - half, cy - half, 1'b1, 1'b0, hole, 1'b0);
    offer_vertex(px, py, cx + half, cy - half, 1'b0, 1'b0, hole, 1'b0);
    offer_vertex(px, py, cx + half, cy + half, 1'b0, 1'b0, hole, 1'b0);
    offer_vertex(px, py, cx - half, cy + half, 1'b0, 1'b1, hole, close_poly);
  endtask

  // well-formed polygon with random rings, sometimes with a flag dropped
  task automatic gen_polygon();
    coord_t      px, py, cx, cy, vx, vy;
    int unsigned span;
    int          rings, nv;
    logic        hole, skip_first, drop_last, poly_end, ring_end;
    case ($urandom_range(0, 3))
      0: span = 16;
      1: span = 4096;
      2: span = 32'd1 << 20;
      default: span = 32'd1 << 30;
    endcase
    if ($urandom_range(0, 3) == 0) begin
      px = wild_coord();
      py = wild_coord();
    end else begin
      px = jitter('0, 100);
      py = jitter('0, 100);
    end
    rings = $urandom_range(1, 3);
    drop_last = ($urandom_range(0, 9) == 0);
    for (int r = 0; r < rings; r++) begin
      cx = jitter(px, span / 2);
      cy = jitter(py, span / 2);
      hole = (r != 0) && ($urandom_range(0, 4) != 0);
      nv = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 6);
      skip_first = (r != 0) && ($urandom_range(0, 9) == 0);
      for (int v = 0; v < nv; v++) begin
        vx = jitter(cx, span);
        vy = ($urandom_range(0, 7) == 0) ? py : jitter(cy, span);
        ring_end = (v == nv - 1);
        poly_end = ring_end && (r == rings - 1);
        offer_vertex(px, py, vx, vy, (v == 0) && !skip_first,
                     ring_end && !(poly_end && drop_last), hole, poly_end);
      end
    end
  endtask

  initial begin : receiver
    int unsigned cyc;
    logic        hold_taken;
    cyc = 0;
    hold_taken = 1'b0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (long_hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      case ((cyc / 128) % 4)
        0: res_ch.ready <= 1'b1;
        1: res_ch.ready <= 1'($urandom_range(0, 1));
        2: res_ch.ready <= ($urandom_range(0, 9) != 0);
        default: res_ch.ready <= ((cyc % 5) < 2);
      endcase
    end
  end

  initial begin : stimulus
    int   random_start;
    logic hold_done, pause_done;
    hold_done = 1'b0;
    pause_done = 1'b0;
    long_hold_req = 1'b0;
    burst_left = 0;
    sent_cnt = 0;
    rst_n <= 1'b0;
    vtx_ch.valid <= 1'b0;
    vtx_ch.point_x <= '0;
    vtx_ch.point_y <= '0;
    vtx_ch.vert_x <= '0;
    vtx_ch.vert_y <= '0;
    vtx_ch.ring_first <= 1'b0;
    vtx_ch.ring_last <= 1'b0;
    vtx_ch.is_hole <= 1'b0;
    vtx_ch.polygon_last <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // plain square around the point
    square_ring('0, '0, '0, '0, 10, 1'b0, 1'b1);
    // outer square with a hole around the point
    square_ring(3, 2, '0, '0, 100, 1'b0, 1'b0);
    tri_ring(3, 2, -20, -20, 30, -10, 0, 40, 1'b1, 1'b1);
    // full-range triangle, ray along the bottom edge
    tri_ring('0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
             32'h8000_0000, '0, 32'h7fff_ffff, 1'b0, 1'b1);
    tri_ring(32'h8000_0000, '0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
             32'h7fff_ffff, 32'h8000_0001, 32'h0000_0001, 1'b0, 1'b1);
    // single-vertex ring
    offer_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                 1'b1, 1'b1, 1'b0, 1'b1);
    // polygon end without ring end
    offer_vertex(1, 1, -8, -8, 1'b1, 1'b0, 1'b0, 1'b0);
    offer_vertex(1, 1, 8, -8, 1'b0, 1'b0, 1'b0, 1'b0);
    offer_vertex(1, 1, 0, 8, 1'b0, 1'b0, 1'b0, 1'b1);
    // ring carried on without a ring start
    offer_vertex(1, 1, 9, 9, 1'b0, 1'b0, 1'b0, 1'b0);
    offer_vertex(1, 1, -9, 9, 1'b0, 1'b1, 1'b0, 1'b1);
    // two outer rings
    tri_ring(5, 5, '0, '0, 10, '0, '0, 10, 1'b0, 1'b0);
    tri_ring(5, 5, 4, 4, 20, 4, 4, 20, 1'b0, 1'b1);

    random_start = sent_cnt;
    while (sent_cnt - random_start < RandomItems) begin
      if (!hold_done && (sent_cnt - random_start > 150)) begin
        // stall the results long enough for the block to back up
        hold_done = 1'b1;
        long_hold_req = 1'b1;
        repeat (12) offer_vertex(wild_coord(), wild_coord(), wild_coord(), wild_coord(),
                                 1'b1, 1'b1, 1'b0, 1'b1);
      end else if (!pause_done && (sent_cnt - random_start > 300)) begin
        pause_done = 1'b1;
        vtx_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_cnt != 0) @(posedge clk);
      end else if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          offer_vertex(wild_coord(), wild_coord(), wild_coord(), wild_coord(),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
      end else begin
        gen_polygon();
      end
    end

    vtx_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if ((mismatch_cnt == 0) && (pending_cnt == 0)) begin
      $display("point_in_polygon_with_holes_top regression: pass");
    end else begin
      $display("point_in_polygon_with_holes_top regression: fail");
    end
    $finish;
  end

endmodule
